>>> rtl/atcd_pkg.sv
// ----------------------------------------------------------------------------
// atcd_pkg
// Shared widths, angle constants and the per-transaction flag bundle for the
// cubic atan2 pipeline.
// ----------------------------------------------------------------------------
package atcd_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int IN_W  = 11;  // input component width, signed
    localparam int MAG_W = 11;  // |numerator|, at most 1024
    localparam int DEN_W = 12;  // divisor, at most 2048
    localparam int OUT_W = 9;   // angle output width
    localparam int T_W   = 8;   // signed correction term, |t| stays below 70
    localparam int ANG_W = 11;  // signed angle before mirroring

    localparam int COEF_BASE_POS = 45;
    localparam int COEF_LIN      = -56;
    localparam int COEF_CUBE     = 11;
    localparam int COEF_BASE_NEG = 135;
    localparam int ANGLE_HALF    = 180;
    localparam int ANGLE_FULL    = 360;

    typedef struct packed {
        logic y_zero;
        logic y_neg;
        logic x_neg;
        logic q_neg;
    } atcd_flags_t;

endpackage

>>> rtl/atan2_cubic_degrees.sv
// Throughput: one transaction per cycle while m_ready is high; every stage
// advances when the next one is free.
// The divider takes one quotient bit per stage (FRAC_BITS + 1 stages), the polynomial three.
// Reset (aresetn low, synchronous) clears all valid bits; no state carries between items.
// ----------------------------------------------------------------------------
// atan2_cubic_degrees
// Vector angle in whole degrees from a cubic arctangent fit on a fixed-point
// ratio, with quadrant folding and mirroring for negative y.
// ----------------------------------------------------------------------------
module atan2_cubic_degrees
    import atcd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_y_value,
    input  logic signed [IN_W-1:0]  s_x_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_W-1:0]        m_angle_degrees
);

    localparam int S_W = IN_W + 2;

    // front stage: fold into numerator magnitude and divisor
    logic             fa_valid_reg;
    logic             fa_ready;
    logic [MAG_W-1:0] fa_mag_reg;
    logic [DEN_W-1:0] fa_den_reg;
    atcd_flags_t      fa_flags_reg;

    logic signed [S_W-1:0] y_ext;
    logic signed [S_W-1:0] x_ext;
    logic signed [S_W-1:0] ay;
    logic signed [S_W-1:0] num;
    logic signed [S_W-1:0] den;
    logic signed [S_W-1:0] num_abs;
    atcd_flags_t           fa_flags_next;

    logic                  div_in_ready;
    logic                  div_valid;
    logic [FRAC_BITS:0]    div_quot;
    atcd_flags_t           div_flags;

    logic                  poly_in_ready;
    logic                  poly_valid;
    logic signed [T_W-1:0] poly_term;
    atcd_flags_t           poly_flags;

    logic                  out_valid_reg;
    logic                  out_ready;
    logic [OUT_W-1:0]      angle_reg;
    logic signed [ANG_W-1:0] base;
    logic signed [ANG_W-1:0] ang_sum;
    logic signed [ANG_W-1:0] ang_fin;
    logic [OUT_W-1:0]      angle_next;

    always_comb begin
        y_ext   = S_W'(s_y_value);
        x_ext   = S_W'(s_x_value);
        ay      = y_ext[S_W-1] ? -y_ext : y_ext;
        num     = s_x_value[IN_W-1] ? (x_ext + ay) : (x_ext - ay);
        den     = s_x_value[IN_W-1] ? (ay - x_ext) : (x_ext + ay);
        num_abs = num[S_W-1] ? -num : num;
        fa_flags_next.y_zero = (s_y_value == '0);
        fa_flags_next.y_neg  = s_y_value[IN_W-1];
        fa_flags_next.x_neg  = s_x_value[IN_W-1];
        fa_flags_next.q_neg  = num[S_W-1];
    end

    assign fa_ready = !fa_valid_reg || div_in_ready;
    assign s_ready  = fa_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fa_valid_reg <= 1'b0;
        end else if (fa_ready) begin
            fa_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fa_ready && s_valid) begin
            fa_mag_reg   <= num_abs[MAG_W-1:0];
            fa_den_reg   <= den[DEN_W-1:0];
            fa_flags_reg <= fa_flags_next;
        end
    end

    atcd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fa_valid_reg),
        .in_ready  (div_in_ready),
        .in_mag    (fa_mag_reg),
        .in_den    (fa_den_reg),
        .in_flags  (fa_flags_reg),
        .out_valid (div_valid),
        .out_ready (poly_in_ready),
        .out_quot  (div_quot),
        .out_flags (div_flags)
    );

    atcd_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (poly_in_ready),
        .in_quot   (div_quot),
        .in_flags  (div_flags),
        .out_valid (poly_valid),
        .out_ready (out_ready),
        .out_term  (poly_term),
        .out_flags (poly_flags)
    );

    // output stage: add quadrant base, mirror for negative y; zero y gives 0 or 180
    always_comb begin
        base    = poly_flags.x_neg ? ANG_W'(COEF_BASE_NEG) : ANG_W'(COEF_BASE_POS);
        ang_sum = base + ANG_W'(poly_term);
        ang_fin = poly_flags.y_neg ? (ANG_W'(ANGLE_FULL) - ang_sum) : ang_sum;
        if (poly_flags.y_zero) begin
            angle_next = poly_flags.x_neg ? OUT_W'(ANGLE_HALF) : '0;
        end else begin
            angle_next = ang_fin[OUT_W-1:0];
        end
    end

    assign out_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= poly_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && poly_valid) begin
            angle_reg <= angle_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_angle_degrees = angle_reg;

`ifndef ASSERT_OFF
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_degrees <= OUT_W'(ANGLE_FULL)))
        else $error("angle beyond full circle");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fa_valid_reg && !fa_flags_reg.y_zero) |-> (fa_den_reg != '0))
        else $error("zero divisor with nonzero y");

    // a zero vector divides by zero; its quotient is dropped later
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_flags.y_zero) |->
            (div_quot <= (FRAC_BITS + 1)'(1 << FRAC_BITS)))
        else $error("ratio magnitude above one");
`endif

endmodule

>>> rtl/atcd_div.sv
// ----------------------------------------------------------------------------
// atcd_div
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1 stages.
// Computes floor(mag * 2^FRAC_BITS / den) for mag <= den.
// ----------------------------------------------------------------------------
module atcd_div
    import atcd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MAG_W-1:0]  in_mag,
    input  logic [DEN_W-1:0]  in_den,
    input  atcd_flags_t       in_flags,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FRAC_BITS:0] out_quot,
    output atcd_flags_t       out_flags
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 1;

    logic             valid_reg [STEPS];
    logic             stg_ready [STEPS];
    logic [DEN_W-1:0] rem_reg   [STEPS];
    logic [DEN_W-1:0] den_reg   [STEPS];
    logic [Q_W-1:0]   q_reg     [STEPS];
    atcd_flags_t      flags_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic             up_valid;
            logic             dn_ready;
            logic [DEN_W-1:0] trial;
            logic [DEN_W-1:0] up_den;
            logic [Q_W-1:0]   up_q;
            atcd_flags_t      up_flags;
            logic             ge;
            logic [DEN_W-1:0] rem_next;
            logic [Q_W-1:0]   q_next;

            if (k == 0) begin : g_first
                assign up_valid = in_valid;
                assign trial    = DEN_W'(in_mag);
                assign up_den   = in_den;
                assign up_q     = '0;
                assign up_flags = in_flags;
            end else begin : g_next
                // shift the partial remainder; the dividend's low bits are all zero
                assign up_valid = valid_reg[k-1];
                assign trial    = {rem_reg[k-1][DEN_W-2:0], 1'b0};
                assign up_den   = den_reg[k-1];
                assign up_q     = q_reg[k-1];
                assign up_flags = flags_reg[k-1];
            end

            if (k == STEPS - 1) begin : g_last
                assign dn_ready = out_ready;
            end else begin : g_mid
                assign dn_ready = stg_ready[k+1];
            end

            assign stg_ready[k] = !valid_reg[k] || dn_ready;
            assign ge           = (trial >= up_den);
            assign rem_next     = ge ? (trial - up_den) : trial;
            assign q_next       = {up_q[Q_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (stg_ready[k]) begin
                    valid_reg[k] <= up_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (stg_ready[k] && up_valid) begin
                    rem_reg[k]   <= rem_next;
                    den_reg[k]   <= up_den;
                    q_reg[k]     <= q_next;
                    flags_reg[k] <= up_flags;
                end
            end
        end
    endgenerate

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[STEPS-1];
    assign out_quot  = q_reg[STEPS-1];
    assign out_flags = flags_reg[STEPS-1];

endmodule

>>> rtl/atcd_poly.sv
// ----------------------------------------------------------------------------
// atcd_poly
// Three-stage polynomial datapath: signs the ratio, forms r^2, r^3 and
// the term (-56*r + 11*r^3) >>> FRAC_BITS.
// ----------------------------------------------------------------------------
module atcd_poly
    import atcd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FRAC_BITS:0]  in_quot,
    input  atcd_flags_t         in_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [T_W-1:0] out_term,
    output atcd_flags_t         out_flags
);

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int R_W   = FRAC_BITS + 2;
    localparam int LIN_W = FRAC_BITS + 8;
    localparam logic signed [LIN_W-1:0] COEF_LIN_S  = LIN_W'(COEF_LIN);
    localparam logic signed [LIN_W-1:0] COEF_CUBE_S = LIN_W'(COEF_CUBE);

    // stage 1: signed ratio, square, linear term
    logic                    p1_valid_reg;
    logic                    p1_ready;
    logic signed [R_W-1:0]   p1_r_reg;
    logic [Q_W-1:0]          p1_r2_reg;
    logic signed [LIN_W-1:0] p1_lin_reg;
    atcd_flags_t             p1_flags_reg;

    logic signed [R_W-1:0]   p1_r_next;
    logic signed [2*R_W-1:0] p1_sq;
    logic [Q_W-1:0]          p1_r2_next;
    logic signed [LIN_W-1:0] p1_r_wide;
    logic signed [LIN_W-1:0] p1_lin_next;

    // stage 2: cube
    logic                    p2_valid_reg;
    logic                    p2_ready;
    logic signed [R_W-1:0]   p2_r3_reg;
    logic signed [LIN_W-1:0] p2_lin_reg;
    atcd_flags_t             p2_flags_reg;

    logic signed [2*R_W-1:0] p2_prod;
    logic signed [2*R_W-1:0] p2_prod_sh;
    logic signed [R_W-1:0]   p2_r3_next;

    // stage 3: combine and scale
    logic                    p3_valid_reg;
    logic                    p3_ready;
    logic signed [T_W-1:0]   p3_term_reg;
    atcd_flags_t             p3_flags_reg;

    logic signed [LIN_W-1:0] p3_r3_wide;
    logic signed [LIN_W-1:0] p3_sum;
    logic signed [LIN_W-1:0] p3_sum_sh;
    logic signed [T_W-1:0]   p3_term_next;

    assign p3_ready = !p3_valid_reg || out_ready;
    assign p2_ready = !p2_valid_reg || p3_ready;
    assign p1_ready = !p1_valid_reg || p2_ready;
    assign in_ready = p1_ready;

    always_comb begin
        p1_r_next   = in_flags.q_neg ? -$signed({1'b0, in_quot}) : $signed({1'b0, in_quot});
        p1_sq       = p1_r_next * p1_r_next;
        p1_r2_next  = p1_sq[FRAC_BITS +: Q_W];
        p1_r_wide   = LIN_W'(p1_r_next);
        p1_lin_next = p1_r_wide * COEF_LIN_S;
    end

    always_comb begin
        p2_prod    = $signed({1'b0, p1_r2_reg}) * p1_r_reg;
        p2_prod_sh = p2_prod >>> FRAC_BITS;
        p2_r3_next = p2_prod_sh[R_W-1:0];
    end

    always_comb begin
        p3_r3_wide   = LIN_W'(p2_r3_reg);
        p3_sum       = p2_lin_reg + p3_r3_wide * COEF_CUBE_S;
        p3_sum_sh    = p3_sum >>> FRAC_BITS;
        p3_term_next = p3_sum_sh[T_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (p1_ready) begin
                p1_valid_reg <= in_valid;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && in_valid) begin
            p1_r_reg     <= p1_r_next;
            p1_r2_reg    <= p1_r2_next;
            p1_lin_reg   <= p1_lin_next;
            p1_flags_reg <= in_flags;
        end
        if (p2_ready && p1_valid_reg) begin
            p2_r3_reg    <= p2_r3_next;
            p2_lin_reg   <= p1_lin_reg;
            p2_flags_reg <= p1_flags_reg;
        end
        if (p3_ready && p2_valid_reg) begin
            p3_term_reg  <= p3_term_next;
            p3_flags_reg <= p2_flags_reg;
        end
    end

    assign out_valid = p3_valid_reg;
    assign out_term  = p3_term_reg;
    assign out_flags = p3_flags_reg;

endmodule
